// ----- sv/rv32i_instruction_step_core_macros.svh -----
// Assertion macros used by the checker file rvs_checker.sv.
`ifndef RV32I_INSTRUCTION_STEP_CORE_MACROS_SVH
`define RV32I_INSTRUCTION_STEP_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/rvs_pkg.sv -----
package rvs_pkg;

    localparam int unsigned MEM_WORDS_DEF = 4096;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

    localparam logic CMD_MEM_WRITE = 1'b0;
    localparam logic CMD_EXECUTE   = 1'b1;

    typedef enum logic [2:0] {
        ALU_ADD  = 3'd0,
        ALU_SLL  = 3'd1,
        ALU_SLT  = 3'd2,
        ALU_SLTU = 3'd3,
        ALU_XOR  = 3'd4,
        ALU_SR   = 3'd5,
        ALU_OR   = 3'd6,
        ALU_AND  = 3'd7
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_MEM,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_alu_op op;
        logic    alt;
    } t_alu_ctl;

endpackage

// ----- sv/rvs_alu.sv -----
module rvs_alu (
    input  rvs_pkg::t_alu_ctl i_ctl,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic [31:0]       o_y
);

    logic [4:0]  sh;
    logic [32:0] diff;

    assign sh   = i_b[4:0];
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        unique case (i_ctl.op)
            rvs_pkg::ALU_ADD:  o_y = i_ctl.alt ? diff[31:0] : i_a + i_b;
            rvs_pkg::ALU_SLL:  o_y = i_a << sh;
            rvs_pkg::ALU_SLT:  o_y = {31'd0, (i_a[31] ^ i_b[31]) ? i_a[31] : diff[32]};
            rvs_pkg::ALU_SLTU: o_y = {31'd0, diff[32]};
            rvs_pkg::ALU_XOR:  o_y = i_a ^ i_b;
            rvs_pkg::ALU_SR:   o_y = i_ctl.alt ? 32'($signed(i_a) >>> sh) : i_a >> sh;
            rvs_pkg::ALU_OR:   o_y = i_a | i_b;
            rvs_pkg::ALU_AND:  o_y = i_a & i_b;
            default:           o_y = i_a & i_b;
        endcase
    end

endmodule

// ----- sv/rvs_mem.sv -----
module rvs_mem #(
    parameter int unsigned MEM_WORDS = rvs_pkg::MEM_WORDS_DEF,
    localparam int unsigned AW = $clog2(MEM_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [MEM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/rvs_regfile.sv -----
module rvs_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [4:0]  i_ra,
    input  logic [4:0]  i_rb,
    output logic [31:0] o_a,
    output logic [31:0] o_b
);

    logic [31:0] r_regs [32];
    logic [31:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we && i_waddr != 5'd0) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_regs[i_waddr] <= i_wdata;
        end
    end

    assign o_a = r_valid[i_ra] ? r_regs[i_ra] : 32'd0;
    assign o_b = r_valid[i_rb] ? r_regs[i_rb] : 32'd0;

endmodule

// ----- sv/rv32i_instruction_step_core.sv -----
// RV32I core with a private word memory. Opcode 0 loads one memory word and
// answers; opcode 1 runs one instruction through fetch, decode and execute,
// and loads and stores add a MEM state for the data word read on the single
// memory read port. All address, branch target and ALU arithmetic goes
// through one shared ALU, used once for the pc step and once for the
// operation. The result is held in an output register until taken; a new
// transaction is accepted once it has left. Writing the start pc register
// also loads the pc. No clearing pass runs after reset.
module rv32i_instruction_step_core #(
    parameter int unsigned MEM_WORDS = rvs_pkg::MEM_WORDS_DEF,
    localparam int unsigned AW = $clog2(MEM_WORDS)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [11:0] i_mem_index,
    input  logic [31:0] i_mem_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pc_after,
    output logic        o_halted,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_mem_written,
    output logic [11:0] o_store_index,
    output logic [31:0] o_store_word
);

    rvs_pkg::t_state r_state, n_state;

    logic [31:0] r_pc;
    logic [31:0] r_inst;
    logic [31:0] r_a, r_b;
    logic [31:0] r_next;
    logic [31:0] r_addr;

    logic [31:0] mem_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    logic        rf_we;
    logic [31:0] rf_a, rf_b;

    rvs_pkg::t_alu_ctl alu_ctl;
    logic [31:0] alu_a, alu_b, alu_y;

    logic        in_acc, out_acc;

    // decode
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

    assign op  = r_inst[6:0];
    assign rd  = r_inst[11:7];
    assign f3  = r_inst[14:12];
    assign rs1 = r_inst[19:15];
    assign rs2 = r_inst[24:20];
    assign f7  = r_inst[31:25];
    assign imm_i = {{20{r_inst[31]}}, r_inst[31:20]};
    assign imm_s = {{20{r_inst[31]}}, r_inst[31:25], r_inst[11:7]};
    assign imm_b = {{19{r_inst[31]}}, r_inst[31], r_inst[7], r_inst[30:25],
                    r_inst[11:8], 1'b0};
    assign imm_j = {{11{r_inst[31]}}, r_inst[31], r_inst[19:12], r_inst[20],
                    r_inst[30:21], 1'b0};
    assign imm_u = {r_inst[31:12], 12'd0};

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign o_stall     = (r_state != rvs_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == rvs_pkg::ST_IDLE);

    rvs_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rvs_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (o_reg_value),
        .i_ra    (rs1),
        .i_rb    (rs2),
        .o_a     (rf_a),
        .o_b     (rf_b)
    );

    rvs_alu u_alu (
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_y   (alu_y)
    );

    // branch compare, on the register reads of the decode cycle
    logic br_take;
    logic lt_s, lt_u;
    assign lt_u = rf_a < rf_b;
    assign lt_s = $signed(rf_a) < $signed(rf_b);
    always_comb begin
        unique case (f3)
            3'd0:    br_take = rf_a == rf_b;
            3'd1:    br_take = rf_a != rf_b;
            3'd4:    br_take = lt_s;
            3'd5:    br_take = !lt_s;
            3'd6:    br_take = lt_u;
            3'd7:    br_take = !lt_u;
            default: br_take = 1'b0;
        endcase
    end

    // ALU operand selection: DECODE computes next pc, EXEC the operation
    always_comb begin
        alu_ctl = '{op: rvs_pkg::ALU_ADD, alt: 1'b0};
        alu_a   = r_pc;
        alu_b   = 32'd4;
        if (r_state == rvs_pkg::ST_DECODE) begin
            alu_a = r_pc;
            unique case (op)
                rvs_pkg::OP_JAL:    alu_b = imm_j;
                rvs_pkg::OP_BRANCH: alu_b = br_take ? imm_b : 32'd4;
                rvs_pkg::OP_JALR: begin
                    alu_a = rf_a;
                    alu_b = imm_i;
                end
                rvs_pkg::OP_SYSTEM: alu_b = (r_inst == rvs_pkg::EBREAK_WORD) ? 32'd0 : 32'd4;
                default:            alu_b = 32'd4;
            endcase
        end else begin
            unique case (op)
                rvs_pkg::OP_AUIPC: alu_b = imm_u;
                rvs_pkg::OP_LOAD: begin
                    alu_a = r_a;
                    alu_b = imm_i;
                end
                rvs_pkg::OP_STORE: begin
                    alu_a = r_a;
                    alu_b = imm_s;
                end
                rvs_pkg::OP_IMM: begin
                    alu_a = r_a;
                    alu_ctl.op = rvs_pkg::t_alu_op'(f3);
                    if (f3 == 3'd1 || f3 == 3'd5) begin
                        alu_b = {27'd0, rs2};
                        alu_ctl.alt = (f3 == 3'd5) && (f7 == rvs_pkg::F7_ALT);
                    end else begin
                        alu_b = imm_i;
                    end
                end
                rvs_pkg::OP_REG: begin
                    alu_a = r_a;
                    alu_b = r_b;
                    alu_ctl.op  = rvs_pkg::t_alu_op'(f3);
                    alu_ctl.alt = (f3 == 3'd0 || f3 == 3'd5) && (f7 == rvs_pkg::F7_ALT);
                end
                default: alu_b = 32'd4;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rvs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == rvs_pkg::CMD_EXECUTE) ? rvs_pkg::ST_FETCH
                                                                 : rvs_pkg::ST_DONE;
                end
            end
            rvs_pkg::ST_FETCH:  n_state = rvs_pkg::ST_DECODE;
            rvs_pkg::ST_DECODE: n_state = rvs_pkg::ST_EXEC;
            rvs_pkg::ST_EXEC: begin
                n_state = (op == rvs_pkg::OP_LOAD || op == rvs_pkg::OP_STORE)
                          ? rvs_pkg::ST_MEM : rvs_pkg::ST_DONE;
            end
            rvs_pkg::ST_MEM:    n_state = rvs_pkg::ST_DONE;
            rvs_pkg::ST_DONE:   if (out_acc) n_state = rvs_pkg::ST_IDLE;
            default:            n_state = rvs_pkg::ST_IDLE;
        endcase
    end

    // load extraction and store merge
    logic [31:0] ld_shift, ld_val, st_word;
    logic        ld_ok, st_ok;
    logic [4:0]  lane_sh;
    logic [31:0] st_mask;
    assign lane_sh  = {r_addr[1:0], 3'd0};
    assign ld_shift = mem_rdata >> lane_sh;
    always_comb begin
        ld_ok  = 1'b1;
        ld_val = 32'd0;
        unique case (f3)
            3'd0:    ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
            3'd1:    ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
            3'd2:    ld_val = mem_rdata;
            3'd4:    ld_val = {24'd0, ld_shift[7:0]};
            3'd5:    ld_val = {16'd0, ld_shift[15:0]};
            default: ld_ok  = 1'b0;
        endcase
        st_ok   = 1'b1;
        st_mask = 32'd0;
        unique case (f3)
            3'd0:    st_mask = 32'h0000_00FF << lane_sh;
            3'd1:    st_mask = 32'h0000_FFFF << lane_sh;
            3'd2:    st_mask = 32'hFFFF_FFFF;
            default: st_ok = 1'b0;
        endcase
        st_word = (mem_rdata & ~st_mask) |
                  (((f3 == 3'd2) ? r_b : (r_b << lane_sh)) & st_mask);
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(i_mem_index);
        mem_wdata = i_mem_word;
        mem_raddr = r_pc[AW+1:2];
        if (r_state == rvs_pkg::ST_IDLE) begin
            mem_we = in_acc && (i_opcode == rvs_pkg::CMD_MEM_WRITE);
        end else if (r_state == rvs_pkg::ST_MEM) begin
            mem_we    = (op == rvs_pkg::OP_STORE) && st_ok;
            mem_waddr = r_addr[AW+1:2];
            mem_wdata = st_word;
        end
        if (r_state == rvs_pkg::ST_EXEC) begin
            mem_raddr = alu_y[AW+1:2];
        end
    end

    assign rf_we = (r_state == rvs_pkg::ST_DONE) && !o_valid && o_reg_written;

    // result valid: o_valid rises in the cycle after DONE entry
    logic r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rvs_pkg::ST_IDLE;
            r_pc    <= 32'd0;
            o_valid <= 1'b0;
            r_fill  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc <= i_cfg_data;
            end else if (r_state == rvs_pkg::ST_DONE && r_fill) begin
                r_pc <= o_pc_after;
            end
            r_fill <= (n_state == rvs_pkg::ST_DONE) && (r_state != rvs_pkg::ST_DONE);
            if (r_fill) begin
                o_valid <= 1'b1;
            end else if (out_acc) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rvs_pkg::ST_FETCH: begin
                r_inst <= mem_rdata;
            end
            rvs_pkg::ST_DECODE: begin
                r_a    <= rf_a;
                r_b    <= rf_b;
                // JALR target has bit 0 cleared
                r_next <= (op == rvs_pkg::OP_JALR) ? {alu_y[31:1], 1'b0} : alu_y;
            end
            rvs_pkg::ST_EXEC: begin
                r_addr <= alu_y;
            end
            default: begin
            end
        endcase
    end

    // link value pc + 4 comes from the ALU default operands in EXEC
    logic [31:0] rd_val;
    logic        rd_wr;
    always_comb begin
        rd_wr  = 1'b0;
        rd_val = 32'd0;
        unique case (op)
            rvs_pkg::OP_LUI:   begin rd_wr = 1'b1; rd_val = imm_u; end
            rvs_pkg::OP_AUIPC: begin rd_wr = 1'b1; rd_val = alu_y; end
            rvs_pkg::OP_JAL, rvs_pkg::OP_JALR: begin
                rd_wr = 1'b1; rd_val = alu_y;
            end
            rvs_pkg::OP_IMM, rvs_pkg::OP_REG: begin rd_wr = 1'b1; rd_val = alu_y; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rvs_pkg::ST_IDLE) begin
            o_pc_after    <= r_pc;
            o_halted      <= 1'b0;
            o_reg_written <= 1'b0;
            o_reg_index   <= 5'd0;
            o_reg_value   <= 32'd0;
            o_mem_written <= 1'b0;
            o_store_index <= 12'd0;
            o_store_word  <= 32'd0;
        end else if (r_state == rvs_pkg::ST_EXEC) begin
            o_pc_after <= r_next;
            o_halted   <= (op == rvs_pkg::OP_SYSTEM) && (r_inst == rvs_pkg::EBREAK_WORD);
            if (rd_wr && rd != 5'd0) begin
                o_reg_written <= 1'b1;
                o_reg_index   <= rd;
                o_reg_value   <= rd_val;
            end
        end else if (r_state == rvs_pkg::ST_MEM) begin
            if (op == rvs_pkg::OP_LOAD && ld_ok && rd != 5'd0) begin
                o_reg_written <= 1'b1;
                o_reg_index   <= rd;
                o_reg_value   <= ld_val;
            end
            if (op == rvs_pkg::OP_STORE && st_ok) begin
                o_mem_written <= 1'b1;
                o_store_index <= 12'(r_addr[AW+1:2]);
                o_store_word  <= st_word;
            end
        end
    end

endmodule

// ----- sv/rvs_checker.sv -----
`include "rv32i_instruction_step_core_macros.svh"

module rvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_halted,
    input logic        o_reg_written,
    input logic [4:0]  o_reg_index,
    input logic        o_mem_written,
    input logic [31:0] o_pc_after
);

    `RVS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `RVS_ASSERT_IMP(a_no_x0_write, i_clk, i_rst_n, o_valid && o_reg_written, o_reg_index != 5'd0)
    `RVS_ASSERT_IMP(a_halt_quiet, i_clk, i_rst_n, o_valid && o_halted,
                    !o_reg_written && !o_mem_written)
    `RVS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                    o_valid && $stable(o_pc_after))

endmodule

bind rv32i_instruction_step_core rvs_checker u_rvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_halted      (o_halted),
    .o_reg_written (o_reg_written),
    .o_reg_index   (o_reg_index),
    .o_mem_written (o_mem_written),
    .o_pc_after    (o_pc_after)
);

// ----- verif/tb_rv32i_instruction_step_core.sv -----
module tb_rv32i_instruction_step_core;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 500;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned PHASE_ITEMS    = 370;

    typedef struct {
        logic        opcode;
        logic [11:0] idx;
        logic [31:0] word;
    } t_item;

    typedef struct {
        logic [31:0] pc_after;
        logic        halted;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [11:0] store_index;
        logic [31:0] store_word;
    } t_retire;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_opcode = 1'b0;
    logic [11:0] in_mem_index = '0;
    logic [31:0] in_mem_word = '0;
    logic        out_stall = 1'b0;

    logic        o_cfg_ready;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_pc_after;
    logic        o_halted;
    logic        o_reg_written;
    logic [4:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_mem_written;
    logic [11:0] o_store_index;
    logic [31:0] o_store_word;

    rv32i_instruction_step_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (o_stall),
        .i_opcode      (in_opcode),
        .i_mem_index   (in_mem_index),
        .i_mem_word    (in_mem_word),
        .o_valid       (o_valid),
        .i_stall       (out_stall),
        .o_pc_after    (o_pc_after),
        .o_halted      (o_halted),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_mem_written (o_mem_written),
        .o_store_index (o_store_index),
        .o_store_word  (o_store_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // shadow core state
    logic [31:0] gpr [32];
    logic [31:0] core_pc;
    logic [31:0] dmem [rvs_pkg::MEM_WORDS_DEF];
    bit          dmem_valid [rvs_pkg::MEM_WORDS_DEF];

    t_item   item_q [$];
    t_retire retire_q [$];
    int      errors = 0;
    bit      hold_go = 1'b0;

    function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt, logic [31:0] a,
                                             logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (rvs_pkg::t_alu_op'(f3))
            rvs_pkg::ALU_ADD:  return alt ? a - b : a + b;
            rvs_pkg::ALU_SLL:  return a << sh;
            rvs_pkg::ALU_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            rvs_pkg::ALU_SLTU: return (a < b) ? 32'd1 : 32'd0;
            rvs_pkg::ALU_XOR:  return a ^ b;
            rvs_pkg::ALU_SR:   return alt ? 32'($signed(a) >>> sh) : a >> sh;
            rvs_pkg::ALU_OR:   return a | b;
            default:           return a & b;
        endcase
    endfunction

    function automatic t_retire retire_inst(t_item it);
        t_retire r;
        logic [31:0] inst, a, b, imm_i, imm_s, imm_b, imm_j, imm_u, nxt, addr, w, f, lane;
        logic [31:0] rdv;
        logic [6:0]  op, f7;
        logic [4:0]  rd, rs1, rs2, sh;
        logic [2:0]  f3;
        logic        wreg, take;
        logic [11:0] wi;
        r = '{default: '0};
        if (it.opcode == rvs_pkg::CMD_MEM_WRITE) begin
            dmem[it.idx] = it.word;
            dmem_valid[it.idx] = 1'b1;
            r.pc_after = core_pc;
            return r;
        end
        inst = dmem[core_pc[13:2]];
        op = inst[6:0]; rd = inst[11:7]; f3 = inst[14:12];
        rs1 = inst[19:15]; rs2 = inst[24:20]; f7 = inst[31:25];
        a = gpr[rs1]; b = gpr[rs2];
        imm_i = {{20{inst[31]}}, inst[31:20]};
        imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
        imm_b = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        imm_j = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        imm_u = {inst[31:12], 12'd0};
        nxt = core_pc + 32'd4;
        wreg = 1'b0; rdv = '0;
        case (op)
            rvs_pkg::OP_LUI:   begin wreg = 1'b1; rdv = imm_u; end
            rvs_pkg::OP_AUIPC: begin wreg = 1'b1; rdv = core_pc + imm_u; end
            rvs_pkg::OP_JAL: begin
                wreg = 1'b1; rdv = core_pc + 32'd4; nxt = core_pc + imm_j;
            end
            rvs_pkg::OP_JALR: begin
                wreg = 1'b1; rdv = core_pc + 32'd4; nxt = (a + imm_i) & ~32'd1;
            end
            rvs_pkg::OP_BRANCH: begin
                case (f3)
                    3'd0:    take = (a == b);
                    3'd1:    take = (a != b);
                    3'd4:    take = ($signed(a) < $signed(b));
                    3'd5:    take = !($signed(a) < $signed(b));
                    3'd6:    take = (a < b);
                    3'd7:    take = (a >= b);
                    default: take = 1'b0;
                endcase
                if (take) nxt = core_pc + imm_b;
            end
            rvs_pkg::OP_LOAD: begin
                addr = a + imm_i;
                w = dmem[addr[13:2]];
                f = w >> (addr[1:0] * 8);
                wreg = 1'b1;
                case (f3)
                    3'd0:    rdv = {{24{f[7]}}, f[7:0]};
                    3'd1:    rdv = {{16{f[15]}}, f[15:0]};
                    3'd2:    rdv = w;
                    3'd4:    rdv = {24'd0, f[7:0]};
                    3'd5:    rdv = {16'd0, f[15:0]};
                    default: wreg = 1'b0;
                endcase
            end
            rvs_pkg::OP_STORE: begin
                addr = a + imm_s;
                wi = addr[13:2];
                sh = {addr[1:0], 3'b000};
                case (f3)
                    3'd0:    lane = 32'h0000_00FF;
                    3'd1:    lane = 32'h0000_FFFF;
                    3'd2:    begin lane = 32'hFFFF_FFFF; sh = '0; end
                    default: lane = '0;
                endcase
                if (lane != '0) begin
                    r.store_word = (dmem[wi] & ~(lane << sh)) | ((b & lane) << sh);
                    dmem[wi] = r.store_word;
                    dmem_valid[wi] = 1'b1;
                    r.store_index = wi;
                    r.mem_written = 1'b1;
                end
            end
            rvs_pkg::OP_IMM: begin
                wreg = 1'b1;
                if (f3 == 3'd1 || f3 == 3'd5)
                    rdv = alu_calc(f3, f3 == 3'd5 && f7 == rvs_pkg::F7_ALT, a, {27'd0, rs2});
                else
                    rdv = alu_calc(f3, 1'b0, a, imm_i);
            end
            rvs_pkg::OP_REG: begin
                wreg = 1'b1;
                rdv = alu_calc(f3, (f3 == 3'd0 || f3 == 3'd5) && f7 == rvs_pkg::F7_ALT,
                               a, b);
            end
            rvs_pkg::OP_SYSTEM: begin
                if (inst == rvs_pkg::EBREAK_WORD) begin
                    r.halted = 1'b1;
                    nxt = core_pc;
                end
            end
            default: ;
        endcase
        if (wreg && rd != '0) begin
            gpr[rd] = rdv;
            r.reg_written = 1'b1;
            r.reg_index = rd;
            r.reg_value = rdv;
        end
        core_pc = nxt;
        r.pc_after = nxt;
        return r;
    endfunction

    task automatic push_item(logic opcode, logic [11:0] idx, logic [31:0] word);
        t_item it;
        it.opcode = opcode; it.idx = idx; it.word = word;
        item_q.push_back(it);
        retire_q.push_back(retire_inst(it));
    endtask

    function automatic logic [31:0] rand_inst();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(13))
            0: w[6:0] = rvs_pkg::OP_LUI;
            1: w[6:0] = rvs_pkg::OP_AUIPC;
            2: w[6:0] = rvs_pkg::OP_JAL;
            3: w[6:0] = rvs_pkg::OP_JALR;
            4, 5: w[6:0] = rvs_pkg::OP_BRANCH;
            6: w[6:0] = rvs_pkg::OP_LOAD;
            7: w[6:0] = rvs_pkg::OP_STORE;
            8, 9: w[6:0] = rvs_pkg::OP_IMM;
            10, 11: w[6:0] = rvs_pkg::OP_REG;
            12: w = ($urandom_range(2) == 0) ? {w[31:7], rvs_pkg::OP_SYSTEM}
                                             : rvs_pkg::EBREAK_WORD;
            default: ;
        endcase
        if (w != rvs_pkg::EBREAK_WORD) begin
            case ($urandom_range(2))
                0: w[31:25] = rvs_pkg::F7_ALT;
                1: w[31:25] = '0;
                default: ;
            endcase
            // equal operands make branches and SUB interesting
            if ($urandom_range(3) == 0) w[24:20] = w[19:15];
            if ($urandom_range(5) == 0) w[19:15] = '0;
        end
        return w;
    endfunction

    // run one instruction, loading whatever words it needs first
    task automatic exec_step(bit fresh);
        logic [11:0] fi;
        logic [31:0] inst, addr;
        fi = core_pc[13:2];
        if (fresh || !dmem_valid[fi] ||
            (dmem[fi] == rvs_pkg::EBREAK_WORD && $urandom_range(3) != 0))
            push_item(rvs_pkg::CMD_MEM_WRITE, fi, rand_inst());
        inst = dmem[fi];
        addr = '0;
        if (inst[6:0] == rvs_pkg::OP_LOAD)
            addr = gpr[inst[19:15]] + {{20{inst[31]}}, inst[31:20]};
        else if (inst[6:0] == rvs_pkg::OP_STORE)
            addr = gpr[inst[19:15]] + {{20{inst[31]}}, inst[31:25], inst[11:7]};
        if ((inst[6:0] == rvs_pkg::OP_LOAD || inst[6:0] == rvs_pkg::OP_STORE) &&
            !dmem_valid[addr[13:2]])
            push_item(rvs_pkg::CMD_MEM_WRITE, addr[13:2], $urandom);
        push_item(rvs_pkg::CMD_EXECUTE, 12'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        while (item_q.size() != 0 || retire_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        core_pc = value;
    endtask

    task automatic load_and_run(logic [31:0] words [$], int runs);
        foreach (words[k]) push_item(rvs_pkg::CMD_MEM_WRITE, 12'(k), words[k]);
        repeat (runs) push_item(rvs_pkg::CMD_EXECUTE, '0, '0);
    endtask

    initial begin
        logic [31:0] prog [$];
        logic [31:0] entries [5];
        int n;
        foreach (gpr[k]) gpr[k] = '0;
        foreach (dmem[k]) begin dmem[k] = '0; dmem_valid[k] = 1'b0; end
        core_pc = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short hand-built program: sign edges, sw, sb and loads at byte 3, branch, halt
        prog = '{
            {20'h80000, 5'd1, rvs_pkg::OP_LUI},
            {12'hFFF, 5'd0, 3'd0, 5'd2, rvs_pkg::OP_IMM},
            {rvs_pkg::F7_ALT, 5'd31, 5'd1, 3'd5, 5'd3, rvs_pkg::OP_IMM},
            {rvs_pkg::F7_ALT, 5'd2, 5'd0, 3'd0, 5'd4, rvs_pkg::OP_REG},
            {7'd2, 5'd2, 5'd0, 3'd2, 5'd0, rvs_pkg::OP_STORE},
            {7'd2, 5'd4, 5'd0, 3'd0, 5'd3, rvs_pkg::OP_STORE},
            {12'd67, 5'd0, 3'd1, 5'd5, rvs_pkg::OP_LOAD},
            {12'd67, 5'd0, 3'd4, 5'd6, rvs_pkg::OP_LOAD},
            {7'd0, 5'd2, 5'd3, 3'd0, 5'b01000, rvs_pkg::OP_BRANCH},
            32'h0000_0013,
            rvs_pkg::EBREAK_WORD
        };
        load_and_run(prog, 11);
        wait_drained();

        entries = '{32'h0, 32'hFFFF_FFFF, 32'h0000_1000, $urandom, 32'hFFFF_FFFC};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) write_start_pc(entries[ph]);
            if (ph == 2) hold_go <= 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    push_item(rvs_pkg::CMD_MEM_WRITE, 12'($urandom), $urandom);
                    n++;
                end else begin
                    exec_step($urandom_range(9) > 2);
                    n += 2;
                end
                // let the driver catch up so the queue stays short
                while (item_q.size() > 40) @(posedge i_clk);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // sender: bursts and gaps
    t_item drv_item;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                drv_item = item_q.pop_front();
                in_valid <= 1'b1;
                in_opcode <= drv_item.opcode;
                in_mem_index <= drv_item.idx;
                in_mem_word <= drv_item.word;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes mode each time stall_cyc wraps; one long hold-off
    int       hold_left = 0;
    bit       hold_started = 1'b0;
    int       stall_mode = 0;
    bit [5:0] stall_cyc = '0;

    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1'b1;
        if (stall_cyc == '0) stall_mode <= $urandom_range(3);
        if (hold_go && !hold_started) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(3) == 0);
                2:       out_stall <= $urandom_range(1);
                default: out_stall <= stall_cyc[3];
            endcase
        end
    end

    // monitor
    t_retire exp_r;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !out_stall) begin
            if (retire_q.size() == 0) begin
                $display("%0t: unexpected transaction, pc_after %h", $time, o_pc_after);
                errors++;
            end else begin
                exp_r = retire_q.pop_front();
                if (o_pc_after !== exp_r.pc_after) begin
                    $display("%0t: pc_after exp %h got %h", $time, exp_r.pc_after, o_pc_after);
                    errors++;
                end
                if (o_halted !== exp_r.halted) begin
                    $display("%0t: halted exp %b got %b", $time, exp_r.halted, o_halted);
                    errors++;
                end
                if (o_reg_written !== exp_r.reg_written) begin
                    $display("%0t: reg_written exp %b got %b", $time, exp_r.reg_written,
                             o_reg_written);
                    errors++;
                end
                if (o_reg_index !== exp_r.reg_index) begin
                    $display("%0t: reg_index exp %0d got %0d", $time, exp_r.reg_index,
                             o_reg_index);
                    errors++;
                end
                if (o_reg_value !== exp_r.reg_value) begin
                    $display("%0t: reg_value exp %h got %h", $time, exp_r.reg_value,
                             o_reg_value);
                    errors++;
                end
                if (o_mem_written !== exp_r.mem_written) begin
                    $display("%0t: mem_written exp %b got %b", $time, exp_r.mem_written,
                             o_mem_written);
                    errors++;
                end
                if (o_store_index !== exp_r.store_index) begin
                    $display("%0t: store_index exp %h got %h", $time, exp_r.store_index,
                             o_store_index);
                    errors++;
                end
                if (o_store_word !== exp_r.store_word) begin
                    $display("%0t: store_word exp %h got %h", $time, exp_r.store_word,
                             o_store_word);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall) || (cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rvs_pkg.sv
sv/rvs_alu.sv
sv/rvs_mem.sv
sv/rvs_regfile.sv
sv/rv32i_instruction_step_core.sv
sv/rvs_checker.sv
verif/tb_rv32i_instruction_step_core.sv
